### src/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and codes for the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_ALL,
        MODE_LIN,
        MODE_ONE,
        MODE_TWO
    } mode_t;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ONE  = 2'd1;
    localparam logic [1:0] KIND_TWO  = 2'd2;
    localparam logic [1:0] KIND_ALL  = 2'd3;

    // control carried alongside the square root
    typedef struct packed {
        mode_t mode;
        logic  a_neg;
        logic  b_neg;
        logic  lin_neg;
    } ctl_t;

    // control carried alongside the first divider lane
    typedef struct packed {
        logic [1:0] kind;
        logic       one_on;
        logic       two_on;
        logic       neg_one;
    } res_t;

endpackage

### src/qrs_mul.sv
// ----------------------------------------------------------------------------
// qrs_mul
// Two unsigned products in two stages: half-width partial products, then sum.
// ----------------------------------------------------------------------------
module qrs_mul #(
    parameter int WIDTH  = 32,
    parameter int SIDE_W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic [WIDTH-1:0]     x0,
    input  logic [WIDTH-1:0]     y0,
    input  logic [WIDTH-1:0]     x1,
    input  logic [WIDTH-1:0]     y1,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 valid_out,
    output logic [2*WIDTH-1:0]   p0,
    output logic [2*WIDTH-1:0]   p1,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int LO = WIDTH / 2;
    localparam int HI = WIDTH - LO;
    localparam int PW = 2 * WIDTH;

    logic [WIDTH+LO-1:0] lo0_reg, lo1_reg;
    logic [WIDTH+HI-1:0] hi0_reg, hi1_reg;
    logic [SIDE_W-1:0]   side_a_reg;
    logic                valid_a_reg;
    logic [PW-1:0]       p0_reg, p1_reg;
    logic [SIDE_W-1:0]   side_b_reg;
    logic                valid_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= valid_in;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo0_reg    <= (WIDTH+LO)'(x0) * (WIDTH+LO)'(y0[LO-1:0]);
            hi0_reg    <= (WIDTH+HI)'(x0) * (WIDTH+HI)'(y0[WIDTH-1:LO]);
            lo1_reg    <= (WIDTH+LO)'(x1) * (WIDTH+LO)'(y1[LO-1:0]);
            hi1_reg    <= (WIDTH+HI)'(x1) * (WIDTH+HI)'(y1[WIDTH-1:LO]);
            side_a_reg <= side_in;
            p0_reg     <= PW'(lo0_reg) + (PW'(hi0_reg) << LO);
            p1_reg     <= PW'(lo1_reg) + (PW'(hi1_reg) << LO);
            side_b_reg <= side_a_reg;
        end
    end

    assign valid_out = valid_b_reg;
    assign p0        = p0_reg;
    assign p1        = p1_reg;
    assign side_out  = side_b_reg;

endmodule

### src/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// Integer square root, one result bit per pipeline stage (restoring form).
// ----------------------------------------------------------------------------
module qrs_sqrt #(
    parameter int OUT_W  = 33,
    parameter int SIDE_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  logic [2*OUT_W-1:0]    value,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  valid_out,
    output logic [OUT_W-1:0]      root,
    output logic [SIDE_W-1:0]     side_out
);

    localparam int VW = 2 * OUT_W;
    localparam int RW = OUT_W + 3;

    logic [RW-1:0]     rem_reg   [OUT_W];
    logic [OUT_W-1:0]  root_reg  [OUT_W];
    logic [VW-1:0]     val_reg   [OUT_W];
    logic [SIDE_W-1:0] side_reg  [OUT_W];
    logic              valid_reg [OUT_W];

    for (genvar k = 0; k < OUT_W; k++)
    begin : g_stage
        logic [RW-1:0]     rem_in;
        logic [OUT_W-1:0]  root_in;
        logic [VW-1:0]     val_in;
        logic [SIDE_W-1:0] side_pre;
        logic              valid_pre;
        logic [RW-1:0]     rem_next;
        logic [RW-1:0]     trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign rem_in    = '0;
            assign root_in   = '0;
            assign val_in    = value;
            assign side_pre  = side_in;
            assign valid_pre = valid_in;
        end
        else
        begin : g_rest
            assign rem_in    = rem_reg[k-1];
            assign root_in   = root_reg[k-1];
            assign val_in    = val_reg[k-1];
            assign side_pre  = side_reg[k-1];
            assign valid_pre = valid_reg[k-1];
        end

        // bring down two bits, try root*4+1
        always_comb
        begin
            rem_next = {rem_in[RW-3:0], val_in[VW-1:VW-2]};
            trial    = RW'({root_in, 2'b01});
            ge       = (rem_next >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_pre;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? (rem_next - trial) : rem_next;
                root_reg[k] <= {root_in[OUT_W-2:0], ge};
                val_reg[k]  <= val_in << 2;
                side_reg[k] <= side_pre;
            end
        end
    end

    assign valid_out = valid_reg[OUT_W-1];
    assign root      = root_reg[OUT_W-1];
    assign side_out  = side_reg[OUT_W-1];

endmodule

### src/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// Unsigned restoring divider, one quotient bit per stage, with an overflow
// check up front for quotients that do not fit QUO_W bits.
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int NUM_W  = 50,
    parameter int DEN_W  = 33,
    parameter int QUO_W  = 33,
    parameter int SIDE_W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic [NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 valid_out,
    output logic [QUO_W-1:0]     quo,
    output logic                 ovf,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int HW = NUM_W - QUO_W;
    localparam int CW = (HW > DEN_W) ? HW : DEN_W;

    logic [DEN_W-1:0]  rem_reg   [QUO_W+1];
    logic [QUO_W-1:0]  low_reg   [QUO_W+1];
    logic [QUO_W-1:0]  quo_reg   [QUO_W+1];
    logic [DEN_W-1:0]  den_reg   [QUO_W+1];
    logic              ovf_reg   [QUO_W+1];
    logic [SIDE_W-1:0] side_reg  [QUO_W+1];
    logic              valid_reg [QUO_W+1];

    logic [CW-1:0] head;
    logic          head_ovf;

    // a top part already at or above the divisor means the quotient overflows
    always_comb
    begin
        head     = CW'(num[NUM_W-1:QUO_W]);
        head_ovf = (head >= CW'(den));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= head_ovf ? '0 : head[DEN_W-1:0];
            low_reg[0]  <= num[QUO_W-1:0];
            quo_reg[0]  <= '0;
            den_reg[0]  <= den;
            ovf_reg[0]  <= head_ovf;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_stage
        logic [DEN_W:0] trial;
        logic           ge;

        always_comb
        begin
            trial = {rem_reg[k-1], low_reg[k-1][QUO_W-1]};
            ge    = (trial >= {1'b0, den_reg[k-1]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? DEN_W'(trial - {1'b0, den_reg[k-1]}) : trial[DEN_W-1:0];
                low_reg[k]  <= low_reg[k-1] << 1;
                quo_reg[k]  <= {quo_reg[k-1][QUO_W-2:0], ge};
                den_reg[k]  <= den_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign valid_out = valid_reg[QUO_W];
    assign quo       = quo_reg[QUO_W];
    assign ovf       = ovf_reg[QUO_W];
    assign side_out  = side_reg[QUO_W];

endmodule

### src/quadratic_root_solver.sv
// Throughput: one word per cycle; the square root and both dividers are fully
// pipelined at one bit per stage, and the whole pipeline holds while a result
// waits on out_stall.
// Reset: rst_n clears every valid bit at once; no clearing pass.
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2+b*x+c in signed fixed point, with saturation flag.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [WORD_BITS-1:0] coef_a,
    input  logic signed [WORD_BITS-1:0] coef_b,
    input  logic signed [WORD_BITS-1:0] coef_c,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  root_kind,
    output logic signed [WORD_BITS-1:0] root_one,
    output logic signed [WORD_BITS-1:0] root_two,
    output logic                        saturated
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int P   = 2 * W + 2;
    localparam int R   = W + 1;
    localparam int NW  = W + 2 + F;
    localparam int DW  = W + 1;
    localparam int Q   = W + 1;
    localparam int SW1 = 3 + 3 * W;
    localparam int CTW = $bits(qrs_pkg::ctl_t);
    localparam int SW2 = CTW + 3 * W;
    localparam int RSW = $bits(qrs_pkg::res_t);
    localparam logic [Q-1:0] LIM_NEG = Q'(1) << (W - 1);
    localparam logic [Q-1:0] LIM_POS = LIM_NEG - 1'b1;

    logic en;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // ---------------- split into sign and magnitude
    logic         s1_valid_reg;
    logic         a_neg_reg, b_neg_reg, c_neg_reg;
    logic [W-1:0] a_mag_reg, b_mag_reg, c_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_neg_reg <= coef_a[W-1];
            b_neg_reg <= coef_b[W-1];
            c_neg_reg <= coef_c[W-1];
            a_mag_reg <= coef_a[W-1] ? W'(-coef_a) : W'(coef_a);
            b_mag_reg <= coef_b[W-1] ? W'(-coef_b) : W'(coef_b);
            c_mag_reg <= coef_c[W-1] ? W'(-coef_c) : W'(coef_c);
        end
    end

    // ---------------- b*b and a*c
    logic           m_valid;
    logic [2*W-1:0] m_bb, m_ac;
    logic [SW1-1:0] m_side;

    qrs_mul #(
        .WIDTH  (W),
        .SIDE_W (SW1)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (s1_valid_reg),
        .x0        (b_mag_reg),
        .y0        (b_mag_reg),
        .x1        (a_mag_reg),
        .y1        (c_mag_reg),
        .side_in   ({a_neg_reg, b_neg_reg, c_neg_reg, a_mag_reg, b_mag_reg, c_mag_reg}),
        .valid_out (m_valid),
        .p0        (m_bb),
        .p1        (m_ac),
        .side_out  (m_side)
    );

    // ---------------- discriminant and case decision
    logic         m_a_neg, m_b_neg, m_c_neg;
    logic [W-1:0] m_am, m_bm, m_cm;
    logic [P:0]   diff;
    logic [P-1:0] disc_next;
    qrs_pkg::ctl_t ctl_next;

    assign {m_a_neg, m_b_neg, m_c_neg, m_am, m_bm, m_cm} = m_side;

    always_comb
    begin
        diff              = {3'b000, m_bb} - {1'b0, m_ac, 2'b00};
        disc_next         = '0;
        ctl_next.a_neg    = m_a_neg;
        ctl_next.b_neg    = m_b_neg;
        ctl_next.lin_neg  = !(m_c_neg ^ m_b_neg);
        ctl_next.mode     = qrs_pkg::MODE_NONE;
        if (m_am == '0)
        begin
            if (m_bm != '0)
                ctl_next.mode = qrs_pkg::MODE_LIN;
            else if (m_cm == '0)
                ctl_next.mode = qrs_pkg::MODE_ALL;
        end
        else if (m_a_neg != m_c_neg && m_cm != '0)
        begin
            // opposite signs: 4ac adds
            ctl_next.mode = qrs_pkg::MODE_TWO;
            disc_next     = {2'b00, m_bb} + {m_ac, 2'b00};
        end
        else if (diff[P])
            ctl_next.mode = qrs_pkg::MODE_NONE;
        else if (diff == '0)
            ctl_next.mode = qrs_pkg::MODE_ONE;
        else
        begin
            ctl_next.mode = qrs_pkg::MODE_TWO;
            disc_next     = diff[P-1:0];
        end
    end

    logic           d_valid_reg;
    logic [P-1:0]   disc_reg;
    logic [SW2-1:0] d_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en)
            d_valid_reg <= m_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disc_reg   <= disc_next;
            d_side_reg <= {ctl_next, m_am, m_bm, m_cm};
        end
    end

    // ---------------- square root
    logic           q_valid;
    logic [R-1:0]   q_root;
    logic [SW2-1:0] q_side;

    qrs_sqrt #(
        .OUT_W  (R),
        .SIDE_W (SW2)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (d_valid_reg),
        .value     (disc_reg),
        .side_in   (d_side_reg),
        .valid_out (q_valid),
        .root      (q_root),
        .side_out  (q_side)
    );

    // ---------------- numerators and divisor
    qrs_pkg::ctl_t q_ctl;
    logic [W-1:0]  q_am, q_bm, q_cm;
    logic signed [W+2:0] b_s, s_s, n1, n2;
    logic [W+1:0]  m1, m2;
    logic [NW-1:0] num1_next, num2_next;
    logic [DW-1:0] den_next;
    qrs_pkg::res_t res_next;
    logic          neg2_next;

    assign {q_ctl, q_am, q_bm, q_cm} = q_side;

    always_comb
    begin
        b_s       = q_ctl.b_neg ? -$signed({3'b000, q_bm}) : $signed({3'b000, q_bm});
        s_s       = $signed({2'b00, q_root});
        n1        = s_s - b_s;
        n2        = -b_s - s_s;
        m1        = n1[W+2] ? W'(0) + (W+2)'(-n1) : (W+2)'(n1);
        m2        = n2[W+2] ? W'(0) + (W+2)'(-n2) : (W+2)'(n2);
        num1_next = '0;
        num2_next = '0;
        den_next  = DW'(1);
        neg2_next = 1'b0;
        res_next.kind    = qrs_pkg::KIND_NONE;
        res_next.one_on  = 1'b0;
        res_next.two_on  = 1'b0;
        res_next.neg_one = 1'b0;
        case (q_ctl.mode)
            qrs_pkg::MODE_ALL:
                res_next.kind = qrs_pkg::KIND_ALL;
            qrs_pkg::MODE_LIN:
            begin
                res_next.kind    = qrs_pkg::KIND_ONE;
                res_next.one_on  = 1'b1;
                res_next.neg_one = q_ctl.lin_neg;
                num1_next        = {2'b00, q_cm, {F{1'b0}}};
                den_next         = {1'b0, q_bm};
            end
            qrs_pkg::MODE_ONE:
            begin
                res_next.kind    = qrs_pkg::KIND_ONE;
                res_next.one_on  = 1'b1;
                res_next.neg_one = !(q_ctl.b_neg ^ q_ctl.a_neg);
                num1_next        = {2'b00, q_bm, {F{1'b0}}};
                den_next         = {q_am, 1'b0};
            end
            qrs_pkg::MODE_TWO:
            begin
                res_next.kind    = qrs_pkg::KIND_TWO;
                res_next.one_on  = 1'b1;
                res_next.two_on  = 1'b1;
                res_next.neg_one = n1[W+2] != q_ctl.a_neg;
                neg2_next        = n2[W+2] != q_ctl.a_neg;
                num1_next        = {m1, {F{1'b0}}};
                num2_next        = {m2, {F{1'b0}}};
                den_next         = {q_am, 1'b0};
            end
            default:
                res_next.kind = qrs_pkg::KIND_NONE;
        endcase
    end

    logic          n_valid_reg;
    logic [NW-1:0] num1_reg, num2_reg;
    logic [DW-1:0] den_reg;
    logic [RSW-1:0] res_reg;
    logic          neg2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_valid_reg <= 1'b0;
        else if (en)
            n_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num1_reg <= num1_next;
            num2_reg <= num2_next;
            den_reg  <= den_next;
            res_reg  <= res_next;
            neg2_reg <= neg2_next;
        end
    end

    // ---------------- two divider lanes
    logic           v1_valid, v2_valid;
    logic [Q-1:0]   quo1, quo2;
    logic           ovf1, ovf2;
    logic [RSW-1:0] v1_side;
    logic           v2_neg;

    qrs_div #(
        .NUM_W  (NW),
        .DEN_W  (DW),
        .QUO_W  (Q),
        .SIDE_W (RSW)
    ) u_div_one (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (n_valid_reg),
        .num       (num1_reg),
        .den       (den_reg),
        .side_in   (res_reg),
        .valid_out (v1_valid),
        .quo       (quo1),
        .ovf       (ovf1),
        .side_out  (v1_side)
    );

    qrs_div #(
        .NUM_W  (NW),
        .DEN_W  (DW),
        .QUO_W  (Q),
        .SIDE_W (1)
    ) u_div_two (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (n_valid_reg),
        .num       (num2_reg),
        .den       (den_reg),
        .side_in   (neg2_reg),
        .valid_out (v2_valid),
        .quo       (quo2),
        .ovf       (ovf2),
        .side_out  (v2_neg)
    );

    // ---------------- clip, apply sign, output register
    function automatic logic [W:0] clip(input logic [Q-1:0] q, input logic over,
                                        input logic neg);
        logic [Q-1:0] lim;
        logic         sat;
        logic [Q-1:0] v;
        logic [Q-1:0] r;
        lim = neg ? LIM_NEG : LIM_POS;
        sat = over || (q > lim);
        v   = sat ? lim : q;
        r   = neg ? (~v + 1'b1) : v;
        return {sat, r[W-1:0]};
    endfunction

    qrs_pkg::res_t v1_res;
    logic [W:0]    c1, c2;

    always_comb
    begin
        v1_res = v1_side;
        c1     = clip(quo1, ovf1, v1_res.neg_one);
        c2     = clip(quo2, ovf2, v2_neg);
    end

    logic [1:0]   root_kind_reg;
    logic [W-1:0] root_one_reg, root_two_reg;
    logic         saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v1_valid && v2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_kind_reg <= v1_res.kind;
            root_one_reg  <= v1_res.one_on ? c1[W-1:0] : '0;
            root_two_reg  <= v1_res.two_on ? c2[W-1:0] : '0;
            saturated_reg <= (v1_res.one_on && c1[W]) || (v1_res.two_on && c2[W]);
        end
    end

    assign out_valid = out_valid_reg;
    assign root_kind = root_kind_reg;
    assign root_one  = root_one_reg;
    assign root_two  = root_two_reg;
    assign saturated = saturated_reg;

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quadratic root solver.
// Directed corner coefficients and then random bursts are fed through a
// valid/stall channel, with a random stall pattern on the result channel.
// A behavioural root predictor queues the expected words, and the monitor
// checks each result word against them.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WB = 32;
    localparam int FB = 16;
    localparam int NUM_RANDOM = 1530;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic signed [WB-1:0] a;
        logic signed [WB-1:0] b;
        logic signed [WB-1:0] c;
    } coefs_t;

    typedef struct {
        logic [1:0]    kind;
        logic [WB-1:0] r1;
        logic [WB-1:0] r2;
        logic          sat;
    } roots_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [WB-1:0] coef_a = '0;
    logic signed [WB-1:0] coef_b = '0;
    logic signed [WB-1:0] coef_c = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] root_kind;
    logic signed [WB-1:0] root_one;
    logic signed [WB-1:0] root_two;
    logic saturated;

    coefs_t pending_coefs[$];
    roots_t expected_roots[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     burst_left = 0;
    int     gap_left = 0;
    int     stall_mode = 0;

    quadratic_root_solver #(.WORD_BITS(WB), .FRAC_BITS(FB)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
        .out_valid(out_valid), .out_stall(out_stall),
        .root_kind(root_kind), .root_one(root_one), .root_two(root_two),
        .saturated(saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // signed quotient truncated toward zero, clipped to the word
    function automatic logic [WB-1:0] clip_div(logic signed [127:0] num,
                                               logic signed [127:0] den,
                                               ref logic sat);
        logic signed [127:0] q;
        q = num / den;
        if (q > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end
        if (q < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return q[WB-1:0];
    endfunction

    function automatic logic signed [127:0] isqrt(logic signed [127:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if ($signed({64'd0, t}) * $signed({64'd0, t}) <= v)
                r = t;
        end
        return $signed({64'd0, r});
    endfunction

    function automatic roots_t solve_roots(coefs_t k);
        roots_t res;
        logic signed [127:0] a, b, c, disc, s, den;
        logic sat;
        a = k.a;
        b = k.b;
        c = k.c;
        sat = 1'b0;
        res = '{qrs_pkg::KIND_NONE, '0, '0, 1'b0};
        if (a == 0)
        begin
            if (b == 0)
                res.kind = (c == 0) ? qrs_pkg::KIND_ALL : qrs_pkg::KIND_NONE;
            else
            begin
                res.kind = qrs_pkg::KIND_ONE;
                res.r1 = clip_div(-(c <<< FB), b, sat);
            end
        end
        else
        begin
            disc = b * b - 4 * a * c;
            den = 2 * a;
            if (disc == 0)
            begin
                res.kind = qrs_pkg::KIND_ONE;
                res.r1 = clip_div(-(b <<< FB), den, sat);
            end
            else if (disc > 0)
            begin
                s = isqrt(disc);
                res.kind = qrs_pkg::KIND_TWO;
                res.r1 = clip_div((s - b) <<< FB, den, sat);
                res.r2 = clip_div((-b - s) <<< FB, den, sat);
            end
        end
        res.sat = sat;
        return res;
    endfunction

    function automatic logic [WB-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3, 4: return $urandom_range(0, 8) << 16;
            5: return -($urandom_range(0, 8) << 16);
            6: return $signed($urandom_range(0, 2047)) - 1024;
            default: return $urandom();
        endcase
    endfunction

    task automatic report(string what, logic [WB-1:0] got, logic [WB-1:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    initial
    begin
        logic [WB-1:0] edges[6];
        coefs_t k;
        edges = '{32'h0, 32'h8000_0000, 32'h7fff_ffff,
                  32'h0001_0000, 32'hffff_0000, 32'h1};
        // linear, all-reals, no-root, double-root and two-root cases
        pending_coefs.push_back('{0, 0, 0});
        pending_coefs.push_back('{0, 0, 32'h0001_0000});
        pending_coefs.push_back('{0, 32'h0002_0000, 32'h0004_0000});
        pending_coefs.push_back('{0, 1, 32'h7fff_ffff});
        pending_coefs.push_back('{32'h0001_0000, 0, 32'h0001_0000});
        pending_coefs.push_back('{32'h0001_0000, 32'h0002_0000, 32'h0001_0000});
        pending_coefs.push_back('{32'h0001_0000, 32'hfffd_0000, 32'h0002_0000});
        pending_coefs.push_back('{32'hffff_0000, 0, 32'h0004_0000});
        pending_coefs.push_back('{1, 32'h7fff_ffff, 0});
        pending_coefs.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        pending_coefs.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        for (int i = 0; i < 12; i++)
            pending_coefs.push_back('{edges[$urandom_range(0, 5)],
                                      edges[$urandom_range(0, 5)],
                                      edges[$urandom_range(0, 5)]});
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            k.a = rand_coef();
            k.b = rand_coef();
            k.c = rand_coef();
            pending_coefs.push_back(k);
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_coefs.size() == 0 && !in_valid);
        wait (expected_roots.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_roots.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // driver: bursts of words separated by random gaps
    always @(posedge clk)
    begin
        coefs_t k;
        if (rst_n)
        begin
            if (!in_valid || !in_stall)
            begin
                if (in_valid)
                    expected_roots.push_back(solve_roots('{coef_a, coef_b, coef_c}));
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_coefs.size() > 0)
                begin
                    k = pending_coefs.pop_front();
                    coef_a <= k.a;
                    coef_b <= k.b;
                    coef_c <= k.c;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and result stall pattern
    always @(posedge clk)
    begin
        roots_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_roots.size() == 0)
                    report("unexpected word", root_one, '0);
                else
                begin
                    want = expected_roots.pop_front();
                    if (root_kind !== want.kind) report("root_kind", root_kind, want.kind);
                    if (root_one !== want.r1) report("root_one", root_one, want.r1);
                    if (root_two !== want.r2) report("root_two", root_two, want.r2);
                    if (saturated !== want.sat) report("saturated", saturated, want.sat);
                end
            end
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end
endmodule

### files.f
src/qrs_pkg.sv
src/qrs_mul.sv
src/qrs_sqrt.sv
src/qrs_div.sv
src/quadratic_root_solver.sv
dv/tb.sv
